@@ design/assert_macros.svh @@
// assertion macros shared by the design files
// no dependencies; checks compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");
`define ASSERT_IMPLIES(label, clk, rst, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("sequence violated");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, cause, effect)
`endif
`endif

@@ design/mmpd_pkg.sv @@
// types, constants and the output scaling function of the peak decimator
// no dependencies
`timescale 1ns / 1ps

package mmpd_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_STEP   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEREO = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDE   = 2'd2;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic               stream_end;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] peak_value;
    logic              is_minimum;
  } out_item_t;

  typedef struct packed {
    logic signed [7:0] max_val;
    logic signed [7:0] min_val;
  } pair_t;

  typedef struct packed {
    logic  valid;
    pair_t pair;
  } pair_write_t;

  // divide by 256 toward zero in wide mode, otherwise saturate to a byte
  function automatic logic signed [7:0] scale_peak(input logic signed [15:0] v,
                                                   input logic wide);
    logic signed [16:0] biased;
    logic signed [7:0]  r;
    biased = {v[15], v} + (v[15] ? 17'sd255 : 17'sd0);
    if (wide) begin
      r = biased[15:8];
    end else if (v > 16'sd127) begin
      r = 8'sd127;
    end else if (v < -16'sd128) begin
      r = -8'sd128;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

@@ design/mmpd_front.sv @@
// front end: configuration registers, group tracking and rate accumulator
// depends on mmpd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mmpd_front import mmpd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [FRAC_BITS:0]     cfg_data,
  input  logic                   accept,
  input  in_item_t               item,
  output pair_write_t            wr
);

  localparam logic [FRAC_BITS:0] ONE_FIXED = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS:0] MIN_STEP  = {{FRAC_BITS{1'b0}}, 1'b1};

  logic [FRAC_BITS:0] step_increment;
  logic               stereo_mode;
  logic               wide_samples;

  logic [FRAC_BITS:0] acc;
  logic signed [15:0] group_max;
  logic signed [15:0] group_min;
  logic               slot;

  logic signed [15:0] sample_ext;
  logic signed [15:0] max_next;
  logic signed [15:0] min_next;
  logic               frame_done;
  logic [FRAC_BITS:0] step_eff;
  logic [FRAC_BITS:0] acc_sum;
  logic               emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_increment <= ONE_FIXED;
      stereo_mode    <= 1'b0;
      wide_samples   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STEP:   step_increment <= cfg_data;
        REG_STEREO: stereo_mode    <= cfg_data[0];
        REG_WIDE:   wide_samples   <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    sample_ext = wide_samples ? item.sample_value
                              : {{8{item.sample_value[7]}}, item.sample_value[7:0]};
    max_next   = (sample_ext > group_max) ? sample_ext : group_max;
    min_next   = (sample_ext < group_min) ? sample_ext : group_min;
    frame_done = !stereo_mode || slot;
    priority if (step_increment == '0) begin
      step_eff = MIN_STEP;
    end else if (step_increment > ONE_FIXED) begin
      step_eff = ONE_FIXED;
    end else begin
      step_eff = step_increment;
    end
    // acc stays below one, so the sum stays below two and cannot wrap
    acc_sum = frame_done ? acc + step_eff : acc;
    emit    = acc_sum[FRAC_BITS];
  end

  always_comb begin
    wr.valid        = accept && (emit || item.stream_end);
    wr.pair.max_val = scale_peak(max_next, wide_samples);
    wr.pair.min_val = scale_peak(min_next, wide_samples);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      group_max <= '0;
      group_min <= '0;
      slot      <= 1'b0;
    end else if (accept) begin
      if (item.stream_end) begin
        acc       <= '0;
        group_max <= '0;
        group_min <= '0;
        slot      <= 1'b0;
      end else begin
        slot      <= stereo_mode ? !slot : 1'b0;
        acc       <= {1'b0, acc_sum[FRAC_BITS-1:0]};
        group_max <= emit ? 16'sd0 : max_next;
        group_min <= emit ? 16'sd0 : min_next;
      end
    end
  end

  `ASSERT_ALWAYS(a_acc_below_one, clk, rst, !acc[FRAC_BITS])
  `ASSERT_IMPLIES(a_end_clears, clk, rst, accept && item.stream_end,
                  acc == '0 && slot == 1'b0 && group_max == 16'sd0 && group_min == 16'sd0)

endmodule

@@ design/mmpd_queue.sv @@
// short queue of emitted max/min pairs between front and back end
// depends on mmpd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mmpd_queue import mmpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  pair_write_t wr,
  input  logic        rd,
  output logic        q_full,
  output logic        q_valid,
  output pair_t       q_data
);

  pair_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_rd;

  assign q_full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = slots[rd_ptr];
  assign do_rd   = rd && q_valid;

  always_ff @(posedge clk) begin
    if (wr.valid) begin
      slots[wr_ptr] <= wr.pair;
    end
  end

  // depth is a power of two, so the pointers wrap on their own
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.valid) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd)    rd_ptr <= rd_ptr + 1'b1;
      unique case ({wr.valid, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_no_write_when_full, clk, rst, !(wr.valid && q_full))
  `ASSERT_ALWAYS(a_count_in_range, clk, rst, count <= QCNT_W'(QUEUE_DEPTH))

endmodule

@@ design/mmpd_back.sv @@
// back end: splits each pair into a maximum then a minimum result
// depends on mmpd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mmpd_back import mmpd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  pair_t     q_data,
  output logic      q_rd,
  input  logic      pop,
  output logic      empty,
  output out_item_t peak
);

  logic  hold_valid;
  logic  phase;
  pair_t hold;
  logic  take;
  logic  load;

  assign take  = pop && hold_valid;
  // reload when the register is free or its minimum leaves this cycle
  assign load  = q_valid && (!hold_valid || (take && phase));
  assign q_rd  = load;
  assign empty = !hold_valid;

  always_comb begin
    peak.peak_value = phase ? hold.min_val : hold.max_val;
    peak.is_minimum = phase;
  end

  always_ff @(posedge clk) begin
    if (load) hold <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      phase      <= 1'b0;
    end else if (load) begin
      hold_valid <= 1'b1;
      phase      <= 1'b0;
    end else if (take) begin
      if (!phase) begin
        phase <= 1'b1;
      end else begin
        hold_valid <= 1'b0;
        phase      <= 1'b0;
      end
    end
  end

  `ASSERT_IMPLIES(a_min_follows_max, clk, rst, take && !phase,
                  hold_valid && phase && $stable(hold))
  `ASSERT_ALWAYS(a_phase_only_when_valid, clk, rst, !phase || hold_valid)

endmodule

@@ design/minmax_peak_decimator.sv @@
// top level of the min/max peak envelope decimator
// depends on mmpd_pkg, mmpd_front, mmpd_queue and mmpd_back
`timescale 1ns / 1ps

// Min/max peak envelope decimator. One signed sample is taken per clock
// (push while full is low); a sample never waits on its own computation, so
// full rises only when all four entries of the pair queue are occupied. Each group
// boundary (accumulator reaching one, or a sample flagged stream_end) places
// one pair in that queue, and the result side delivers it as two transfers,
// maximum then minimum, one per cycle while pop is high, through its output
// register. The sustained input rate is therefore one sample per cycle as long
// as group boundaries come at most every second sample and pop stays high; with
// more frequent boundaries the result port, at two transfers per pair, sets the
// rate. Configuration writes take effect on the next cycle and have no read-back.

module minmax_peak_decimator import mmpd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [FRAC_BITS:0]     cfg_data,
  input  logic                   push,
  output logic                   full,
  input  in_item_t               sample,
  output logic                   empty,
  input  logic                   pop,
  output out_item_t              peak
);

  pair_write_t wr;
  logic        accept;
  logic        q_full;
  logic        q_valid;
  logic        q_rd;
  pair_t       q_data;

  assign full   = q_full;
  assign accept = push && !q_full;

  mmpd_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (sample),
    .wr        (wr)
  );

  mmpd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd      (q_rd),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_data  (q_data)
  );

  mmpd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .peak    (peak)
  );

endmodule

@@ tb/sv/peak_envelope_checker.sv @@
// checker for the min/max peak decimator: tracks config writes and sample transfers,
// predicts each max/min result and compares it with what leaves the result port
// depends on mmpd_pkg
`timescale 1ns / 1ps

module peak_envelope_checker import mmpd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [FRAC_BITS:0]     cfg_data,
  input  logic                   push,
  input  logic                   full,
  input  in_item_t               sample,
  input  logic                   empty,
  input  logic                   pop,
  input  out_item_t              peak,
  output int                     mismatches,
  output int                     outstanding
);

  localparam int UNIT_STEP = 1 << FRAC_BITS;
  localparam int SHOWN_MAX = 10;

  logic [FRAC_BITS:0] step_reg;
  logic               stereo_reg;
  logic               wide_reg;

  int   rate_acc;
  int   grp_hi;
  int   grp_lo;
  logic slot;

  out_item_t peak_expect_q[$];
  int        fail_cnt = 0;

  function automatic logic signed [7:0] byte_peak(input int v);
    int r;
    r = wide_reg ? v / 256 : v;
    if (r > 127) r = 127;
    if (r < -128) r = -128;
    return r[7:0];
  endfunction

  task automatic clear_group();
    rate_acc = 0;
    grp_hi   = 0;
    grp_lo   = 0;
    slot     = 1'b0;
  endtask

  task automatic report(input string what, input int want, input int got);
    if (fail_cnt < SHOWN_MAX) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    end
    fail_cnt++;
  endtask

  // one sample in, zero or two expected results out
  task automatic take_sample(input in_item_t it);
    int        v;
    int        step;
    logic      frame_done;
    out_item_t r;
    if (wide_reg) begin
      v = $signed(it.sample_value);
    end else begin
      v = $signed(it.sample_value[7:0]);
    end
    if (v > grp_hi) grp_hi = v;
    if (v < grp_lo) grp_lo = v;
    if (stereo_reg) begin
      frame_done = slot;
      slot = ~slot;
    end else begin
      frame_done = 1'b1;
      slot = 1'b0;
    end
    step = int'(step_reg);
    if (step == 0) step = 1;
    if (step > UNIT_STEP) step = UNIT_STEP;
    if (frame_done) rate_acc += step;
    if (rate_acc >= UNIT_STEP || it.stream_end) begin
      r.peak_value = byte_peak(grp_hi);
      r.is_minimum = 1'b0;
      peak_expect_q = {peak_expect_q, r};
      r.peak_value = byte_peak(grp_lo);
      r.is_minimum = 1'b1;
      peak_expect_q = {peak_expect_q, r};
      if (it.stream_end) begin
        clear_group();
      end else begin
        rate_acc -= UNIT_STEP;
        grp_hi = 0;
        grp_lo = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      step_reg   = {1'b1, {FRAC_BITS{1'b0}}};
      stereo_reg = 1'b0;
      wide_reg   = 1'b0;
      clear_group();
      peak_expect_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_STEP:   step_reg = cfg_data;
          REG_STEREO: stereo_reg = cfg_data[0];
          REG_WIDE:   wide_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (push && !full) take_sample(sample);
      if (pop && !empty) begin
        if (peak_expect_q.size() == 0) begin
          if (fail_cnt < SHOWN_MAX) begin
            $display("%0t: unexpected result: peak_value %0d is_minimum %0b", $realtime,
                     peak.peak_value, peak.is_minimum);
          end
          fail_cnt++;
        end else begin
          want = peak_expect_q[0];
          peak_expect_q.delete(0);
          if (peak.peak_value !== want.peak_value) begin
            report("peak_value", want.peak_value, peak.peak_value);
          end
          if (peak.is_minimum !== want.is_minimum) begin
            report("is_minimum", want.is_minimum, peak.is_minimum);
          end
        end
      end
    end
    outstanding <= peak_expect_q.size();
    mismatches  <= fail_cnt;
  end

endmodule

@@ tb/sv/tb.sv @@
// testbench top for the min/max peak decimator: clock, reset, sample and config
// stimulus, result-side pop, verdict; depends on mmpd_pkg, peak_envelope_checker
`timescale 1ns / 1ps

module tb;
  import mmpd_pkg::*;

  localparam int FRAC_BITS    = 16;
  localparam int STEP_ONE     = 1 << FRAC_BITS;
  localparam int RANDOM_ITEMS = 1800;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int SETTLE       = 6;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_STEP;
  logic [FRAC_BITS:0]     cfg_data = '0;
  logic                   push = 1'b0;
  logic                   full;
  in_item_t               sample = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  out_item_t              peak;
  int                     mismatches;
  int                     outstanding;

  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;

  always #4 clk = ~clk;

  minmax_peak_decimator #(.FRAC_BITS(FRAC_BITS)) u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .sample(sample),
    .empty(empty), .pop(pop), .peak(peak)
  );

  peak_envelope_checker #(.FRAC_BITS(FRAC_BITS)) u_chk (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .sample(sample),
    .empty(empty), .pop(pop), .peak(peak),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // result side stalls about 28% of cycles unless in a calm stretch
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (rx_calm) begin
      pop <= 1'b1;
    end else begin
      pop <= ($urandom_range(99) >= 28);
    end
  end

  task automatic send(input logic [15:0] v, input logic last);
    while (!tx_calm && $urandom_range(99) < 28) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    sample.sample_value <= v;
    sample.stream_end <= last;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // step past the last push first so the count includes the last accepted sample
  task automatic drain();
    int waited;
    waited = 0;
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // upper data bits of the one-bit registers carry junk on purpose
  task automatic configure(input logic [FRAC_BITS:0] step, input logic stereo,
                           input logic wide, input logic stray);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= REG_STEP;
    cfg_data  <= step;
    @(posedge clk);
    cfg_index <= REG_STEREO;
    cfg_data  <= {FRAC_BITS'($urandom), stereo};
    @(posedge clk);
    cfg_index <= REG_WIDE;
    cfg_data  <= {FRAC_BITS'($urandom), wide};
    @(posedge clk);
    if (stray) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= (FRAC_BITS+1)'($urandom);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h007F;
      3: return 16'hFF80;
      4: return 16'h0000;
      5: return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [FRAC_BITS:0] pick_step();
    case ($urandom_range(7))
      0: return '0;
      1: return 17'd1;
      2: return 17'(STEP_ONE);
      3: return 17'($urandom_range(131071, STEP_ONE + 1));
      4: return 17'($urandom_range(STEP_ONE, 1));
      5: return 17'(STEP_ONE / 2);
      6: return 17'(STEP_ONE / 3);
      default: return 17'($urandom_range(8192, 1));
    endcase
  endfunction

  initial begin
    int sent;
    int n;
    logic calm;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config: one pair per sample, only the low byte counts
    send(16'sd127, 1'b0);
    send(-16'sd128, 1'b0);
    send(16'sd0, 1'b0);
    send(16'h7F80, 1'b0);
    send(16'h807F, 1'b0);

    // wide samples: truncation toward zero at both ends
    configure(17'(STEP_ONE), 1'b0, 1'b1, 1'b0);
    send(16'sd32767, 1'b0);
    send(-16'sd32768, 1'b0);
    send(-16'sd255, 1'b0);
    send(-16'sd256, 1'b0);
    send(16'sd255, 1'b1);

    // zero step acts as the smallest step; stream end on half a frame
    configure('0, 1'b1, 1'b0, 1'b0);
    send(16'sd100, 1'b0);
    send(-16'sd50, 1'b0);
    send(16'sd7, 1'b1);

    // step above one is clamped; leave a stereo frame half done
    configure(17'h1FFFF, 1'b1, 1'b1, 1'b0);
    send(16'sd1000, 1'b0);
    send(-16'sd1000, 1'b0);
    send(16'sd20000, 1'b0);

    // drop to mono in the middle of that frame
    configure(17'h1FFFF, 1'b0, 1'b1, 1'b0);
    send(-16'sd20000, 1'b0);

    // width change inside a group saturates the raw value
    configure(17'd1, 1'b0, 1'b1, 1'b0);
    send(16'sd32767, 1'b0);
    configure(17'd1, 1'b0, 1'b0, 1'b0);
    send(16'sd5, 1'b1);

    // write to an index with no register behind it
    configure(17'(STEP_ONE), 1'b0, 1'b0, 1'b1);
    send(-16'sd3, 1'b0);
    send(-16'sd128, 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      configure(pick_step(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                $urandom_range(3) == 0);
      n = $urandom_range(80, 10);
      calm = (sent >= 700 && sent < 1100);
      tx_calm = calm;
      rx_calm <= calm;
      repeat (n) begin
        send(pick_sample(), $urandom_range(24) == 0);
        sent++;
      end
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
